[rtl/cbm_pkg.sv]
// Shared types and constants for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    // Bus access kinds
    typedef enum logic [1:0] {
        OP_ROM_READ   = 2'd0,
        OP_CTRL_WRITE = 2'd1,
        OP_RAM_READ   = 2'd2,
        OP_RAM_WRITE  = 2'd3
    } opcode_t;

    // Which store a result addresses
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2
    } target_t;

    // Fault codes reported with a result
    typedef enum logic [1:0] {
        FLT_OK        = 2'd0,
        FLT_BAD_ROM   = 2'd1,
        FLT_NO_RAM    = 2'd2,
        FLT_RAM_WRITE = 2'd3
    } fault_t;

    // Configuration register indexes
    localparam logic CFG_CART_KIND   = 1'b0;
    localparam logic CFG_RAM_PRESENT = 1'b1;

    // Cartridge kinds
    localparam logic CART_PLAIN  = 1'b0;
    localparam logic CART_BANKED = 1'b1;

    // Store geometry
    localparam int RAM_WINDOW_BYTES = 8192;
    localparam int RAM_OFS_W        = $clog2(RAM_WINDOW_BYTES);
    localparam int ROM_OFS_W        = 14;
    localparam int ROM_PAGE_W       = 7;
    localparam int RAM_PAGE_W       = 2;
    localparam int MEM_ADDR_W       = 21;

    // Control write decode constants
    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [7:0] MODE_SEL_ONE = 8'h01;

    // Control write regions, selected by bus address bits 15:13
    localparam logic [2:0] REG_RAM_EN   = 3'd0;
    localparam logic [2:0] REG_BANK_LO  = 3'd1;
    localparam logic [2:0] REG_BANK_HI  = 3'd2;
    localparam logic [2:0] REG_MODE_SEL = 3'd3;

    typedef struct packed {
        opcode_t     opcode;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
    } req_t;

    typedef struct packed {
        target_t                 target;
        logic [MEM_ADDR_W-1:0]   mem_address;
        logic                    write_enable;
        logic [7:0]              write_data;
        fault_t                  fault;
        logic                    ram_enabled;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/cartridge_bank_mapper_unit.sv]
// Cartridge bank mapper: translates one bus access into a ROM or RAM address.
// A request in the input register is translated combinationally; its result
// is loaded into the result register when that register is empty or drains. Throughput:
// one request per cycle; a held result stalls the input once the input register
// is also full. Reset clears both valid flags, sets the ROM bank to 1 and clears
// the RAM bank, mode, RAM enable flag and both configuration registers.
`default_nettype none

module cartridge_bank_mapper_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic          cfg_data,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire cbm_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output cbm_pkg::rsp_t      rsp
);

    logic cart_kind_reg;
    logic ram_present_reg;

    logic [cbm_pkg::ROM_PAGE_W-1:0] rom_page_reg, rom_page_next;
    logic [cbm_pkg::RAM_PAGE_W-1:0] ram_page_reg, ram_page_next;
    logic                           bank_mode_reg, bank_mode_next;
    logic                           ram_en_reg, ram_en_next;

    logic          in_valid_reg;
    cbm_pkg::req_t in_req_reg;
    logic          out_valid_reg;
    cbm_pkg::rsp_t out_rsp_reg;
    cbm_pkg::rsp_t rsp_next;

    logic advance;
    logic [cbm_pkg::RAM_OFS_W-1:0] ram_ofs;

    // Result register drains or is empty; input stage moves forward
    assign advance   = !out_valid_reg || rsp_ready;
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_kind_reg   <= cbm_pkg::CART_PLAIN;
            ram_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbm_pkg::CFG_CART_KIND:   cart_kind_reg   <= cfg_data;
                cbm_pkg::CFG_RAM_PRESENT: ram_present_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Decode control writes into the next bank state
    always_comb
    begin
        rom_page_next  = rom_page_reg;
        ram_page_next  = ram_page_reg;
        bank_mode_next = bank_mode_reg;
        ram_en_next    = ram_en_reg;
        if (in_req_reg.opcode == cbm_pkg::OP_CTRL_WRITE
            && cart_kind_reg == cbm_pkg::CART_BANKED)
        begin
            unique case (in_req_reg.bus_address[15:13])
                cbm_pkg::REG_RAM_EN:
                    ram_en_next = (in_req_reg.bus_data[3:0] == cbm_pkg::RAM_EN_KEY);
                cbm_pkg::REG_BANK_LO:
                begin
                    rom_page_next[4:0] = (in_req_reg.bus_data[4:0] == 5'd0)
                                       ? 5'd1 : in_req_reg.bus_data[4:0];
                end
                cbm_pkg::REG_BANK_HI:
                begin
                    if (bank_mode_reg)
                        ram_page_next = in_req_reg.bus_data[1:0];
                    else
                        rom_page_next[6:5] = in_req_reg.bus_data[1:0];
                end
                cbm_pkg::REG_MODE_SEL:
                    bank_mode_next = (in_req_reg.bus_data == cbm_pkg::MODE_SEL_ONE);
                default:
                    ;
            endcase
        end
    end

    // Translate the registered request into a result
    assign ram_ofs = in_req_reg.bus_address[cbm_pkg::RAM_OFS_W-1:0];

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.target       = cbm_pkg::TGT_NONE;
        rsp_next.fault        = cbm_pkg::FLT_OK;
        rsp_next.ram_enabled  = ram_en_next;
        unique case (in_req_reg.opcode)
            cbm_pkg::OP_ROM_READ:
            begin
                if (!in_req_reg.bus_address[15])
                begin
                    rsp_next.target = cbm_pkg::TGT_ROM;
                    if (!in_req_reg.bus_address[14])
                        rsp_next.mem_address = cbm_pkg::MEM_ADDR_W'(in_req_reg.bus_address);
                    else
                        rsp_next.mem_address = {rom_page_reg,
                            in_req_reg.bus_address[cbm_pkg::ROM_OFS_W-1:0]};
                end
                else
                begin
                    rsp_next.fault = cbm_pkg::FLT_BAD_ROM;
                end
            end
            cbm_pkg::OP_CTRL_WRITE:
                ;
            cbm_pkg::OP_RAM_READ:
            begin
                if (cart_kind_reg == cbm_pkg::CART_PLAIN)
                begin
                    rsp_next.target      = cbm_pkg::TGT_RAM;
                    rsp_next.mem_address = cbm_pkg::MEM_ADDR_W'(ram_ofs);
                end
                else if (ram_present_reg)
                begin
                    rsp_next.target      = cbm_pkg::TGT_RAM;
                    rsp_next.mem_address = cbm_pkg::MEM_ADDR_W'({ram_page_reg, ram_ofs});
                end
                else
                begin
                    rsp_next.fault = cbm_pkg::FLT_NO_RAM;
                end
            end
            cbm_pkg::OP_RAM_WRITE:
            begin
                if (cart_kind_reg == cbm_pkg::CART_PLAIN)
                begin
                    rsp_next.target       = cbm_pkg::TGT_RAM;
                    rsp_next.mem_address  = cbm_pkg::MEM_ADDR_W'(ram_ofs);
                    rsp_next.write_enable = 1'b1;
                    rsp_next.write_data   = in_req_reg.bus_data;
                end
                else
                begin
                    rsp_next.fault = cbm_pkg::FLT_RAM_WRITE;
                end
            end
            default:
                ;
        endcase
    end

    // Advance the input stage, result stage and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rom_page_reg  <= cbm_pkg::ROM_PAGE_W'(1);
            ram_page_reg  <= '0;
            bank_mode_reg <= 1'b0;
            ram_en_reg    <= 1'b0;
        end
        else
        begin
            if (req_ready)
                in_valid_reg <= req_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
            begin
                rom_page_reg  <= rom_page_next;
                ram_page_reg  <= ram_page_next;
                bank_mode_reg <= bank_mode_next;
                ram_en_reg    <= ram_en_next;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            in_req_reg <= req;
        if (advance && in_valid_reg)
            out_rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire
